@@ src/ibu_pkg.sv @@
// ibu_pkg: shared constants and types of the interleaved bit unpacker
// used by every module under src; depends on nothing
package ibu_pkg;

  localparam int LANES      = 32;
  localparam int LANE_W     = $clog2(LANES);
  localparam int WORD_BITS  = 32;
  localparam int ROWS       = 32;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int WIDTH_W    = 6;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [WIDTH_W-1:0] RESET_WIDTH = 6'd20;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 6'd32;

  typedef struct packed {
    logic [WORD_BITS-1:0] cur;
    logic [WORD_BITS-1:0] prev;
    logic [LANE_W-1:0]    lane;
    logic [ROWS-1:0]      rmask;
    logic [WIDTH_W-1:0]   width;
  } ibu_entry_t;

  typedef struct packed {
    logic       valid;
    ibu_entry_t entry;
  } ibu_head_t;

endpackage

@@ src/ibu_front.sv @@
// ibu_front: accepts packed words, keeps per-lane previous words and a shared lane and word position,
// and works out which rows end in each word; depends on ibu_pkg
module ibu_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ibu_pkg::WIDTH_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ibu_pkg::WORD_BITS-1:0] in_packed_word,
  input  logic                          q_full,
  output logic                          q_push,
  output ibu_pkg::ibu_entry_t           q_entry
);

  logic [ibu_pkg::WIDTH_W-1:0]   width_r;
  logic [ibu_pkg::LANE_W-1:0]    lane_r, lane_nxt;
  logic [ibu_pkg::ROW_W-1:0]     wpos_r, wpos_nxt;
  logic [ibu_pkg::WORD_BITS-1:0] prev_r [ibu_pkg::LANES];
  logic [ibu_pkg::WIDTH_W-1:0]   eff_w;
  logic [ibu_pkg::ROWS-1:0]      rmask;
  logic [ibu_pkg::WIDTH_W:0]     wpos_inc;
  logic [10:0]                   end_bit [ibu_pkg::ROWS];
  logic                          accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    if (width_r == '0) begin
      eff_w = 6'd1;
    end else if (width_r > ibu_pkg::MAX_WIDTH) begin
      eff_w = ibu_pkg::MAX_WIDTH;
    end else begin
      eff_w = width_r;
    end
  end

  // rows whose last bit lies in the current word position
  always_comb begin
    for (int r = 0; r < ibu_pkg::ROWS; r++) begin
      end_bit[r] = 11'(11'(r + 1) * {5'b0, eff_w} - 11'd1);
      rmask[r]   = (end_bit[r][10:5] == {1'b0, wpos_r});
    end
  end

  always_comb begin
    wpos_inc = {2'b0, wpos_r} + 7'd1;
    lane_nxt = lane_r;
    wpos_nxt = wpos_r;
    if (accept) begin
      if (lane_r == ibu_pkg::LANE_W'(ibu_pkg::LANES - 1)) begin
        lane_nxt = '0;
        wpos_nxt = (wpos_inc >= {1'b0, eff_w}) ? '0 : wpos_inc[ibu_pkg::ROW_W-1:0];
      end else begin
        lane_nxt = lane_r + 1'b1;
      end
    end
  end

  assign q_push        = accept && (rmask != '0);
  assign q_entry.cur   = in_packed_word;
  assign q_entry.prev  = prev_r[lane_r];
  assign q_entry.lane  = lane_r;
  assign q_entry.rmask = rmask;
  assign q_entry.width = eff_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= ibu_pkg::RESET_WIDTH;
      lane_r  <= '0;
      wpos_r  <= '0;
    end else begin
      if (cfg_we) begin
        width_r <= cfg_wdata;
      end
      lane_r <= lane_nxt;
      wpos_r <= wpos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_r[lane_r] <= in_packed_word;
    end
  end

endmodule

@@ src/ibu_fifo.sv @@
// ibu_fifo: short queue of classified words between front and back
// depends on ibu_pkg
module ibu_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ibu_pkg::ibu_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output ibu_pkg::ibu_head_t  head
);

  ibu_pkg::ibu_entry_t         mem_r [ibu_pkg::QDEPTH];
  logic [ibu_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [ibu_pkg::QPTR_W:0]    count_r, count_nxt;

  assign full       = (count_r == (ibu_pkg::QPTR_W+1)'(ibu_pkg::QDEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ src/ibu_back.sv @@
// ibu_back: walks the row set of each queued word, one value per cycle while the output is not stalled,
// into the output register; depends on ibu_pkg
module ibu_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ibu_pkg::ibu_head_t            head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ibu_pkg::WORD_BITS-1:0] out_value,
  output logic [4:0]                    out_row,
  output logic [4:0]                    out_lane,
  output logic                          out_last_of_item
);

  ibu_pkg::ibu_entry_t           work_r, work_nxt;
  logic                          work_valid_r, work_valid_nxt;
  logic [ibu_pkg::ROWS-1:0]      rem_r, rem_nxt, rem_clr;
  logic [ibu_pkg::ROW_W-1:0]     row;
  logic [10:0]                   start_bit;
  logic [4:0]                    shift;
  logic                          straddle;
  logic [2*ibu_pkg::WORD_BITS-1:0] pair;
  logic [ibu_pkg::WORD_BITS-1:0] raw, wmask;
  logic                          step, last, done, load;

  logic                          out_valid_r, out_valid_nxt;
  logic [ibu_pkg::WORD_BITS-1:0] out_value_r;
  logic [4:0]                    out_row_r, out_lane_r;
  logic                          out_last_r;

  always_comb begin
    row = '0;
    for (int i = ibu_pkg::ROWS - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        row = ibu_pkg::ROW_W'(i);
      end
    end
  end

  assign rem_clr   = rem_r & ~(ibu_pkg::ROWS'(1) << row);
  assign start_bit = 11'({6'b0, row} * {5'b0, work_r.width});
  assign shift     = start_bit[4:0];
  assign straddle  = ({2'b0, shift} + {1'b0, work_r.width}) > 7'd32;
  assign pair      = {work_r.cur, work_r.prev} >> shift;
  assign raw       = straddle ? pair[ibu_pkg::WORD_BITS-1:0] : (work_r.cur >> shift);
  assign wmask     = ~({ibu_pkg::WORD_BITS{1'b1}} << work_r.width);

  assign step = work_valid_r && (!out_valid_r || !out_stall);
  assign last = (rem_clr == '0);
  assign done = step && last;
  assign load = (!work_valid_r || done) && head.valid;
  assign pop  = load;

  always_comb begin
    work_nxt       = work_r;
    work_valid_nxt = work_valid_r;
    rem_nxt        = rem_r;
    if (load) begin
      work_nxt       = head.entry;
      work_valid_nxt = 1'b1;
      rem_nxt        = head.entry.rmask;
    end else if (done) begin
      work_valid_nxt = 1'b0;
    end else if (step) begin
      rem_nxt = rem_clr;
    end
  end

  assign out_valid_nxt = step ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    if (step) begin
      out_value_r <= raw & wmask;
      out_row_r   <= 5'(row);
      out_lane_r  <= 5'(work_r.lane);
      out_last_r  <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_row          = out_row_r;
  assign out_lane         = out_lane_r;
  assign out_last_of_item = out_last_r;

endmodule

@@ src/interleaved_bit_unpack.sv @@
// interleaved_bit_unpack: top level of the lane-interleaved bit unpacker
// instantiates ibu_front, ibu_fifo and ibu_back; depends on ibu_pkg
//
// Packed words enter word-major, lanes 0 to 31 inside each word position, one word per
// cycle at the front while the four-entry queue has room. Each word yields the rows whose
// last bit falls in it, 32/width values per word on average (about 1.6 at width 20);
// the back emits one value per cycle while out_stall is low, through the single value
// path into the output register. Words that end no row are not queued and produce
// nothing. Values of a word come out in ascending row order with last_of_item on the
// final one. The user must write the value width through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this. 0 acts as 1 and values above 32
// act as 32. The per-lane previous words hold no reset value and need no clearing pass.
module interleaved_bit_unpack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ibu_pkg::WIDTH_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ibu_pkg::WORD_BITS-1:0] in_packed_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ibu_pkg::WORD_BITS-1:0] out_value,
  output logic [4:0]                    out_row,
  output logic [4:0]                    out_lane,
  output logic                          out_last_of_item
);

  logic                q_full, q_push, q_pop;
  ibu_pkg::ibu_entry_t q_entry;
  ibu_pkg::ibu_head_t  q_head;

  ibu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_packed_word (in_packed_word),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_entry)
  );

  ibu_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head)
  );

  ibu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_row          (out_row),
    .out_lane         (out_lane),
    .out_last_of_item (out_last_of_item)
  );

endmodule

@@ src/ibu_checker.sv @@
// ibu_checker: port-level assertions for interleaved_bit_unpack and its bind
// depends on ibu_pkg and on the top level's ports
module ibu_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ibu_pkg::WORD_BITS-1:0] out_value,
  input logic [4:0]                    out_row,
  input logic [4:0]                    out_lane,
  input logic                          out_last_of_item
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_value) && $stable(out_row)
                                && $stable(out_lane) && $stable(out_last_of_item))
    else $error("stalled result changed");

  // values of one word follow back to back, same lane, rising rows
  a_word_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_item |=>
      out_valid && (out_row > $past(out_row)) && (out_lane == $past(out_lane)))
    else $error("rows of one word out of order");

endmodule

bind interleaved_bit_unpack ibu_checker u_ibu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_value        (out_value),
  .out_row          (out_row),
  .out_lane         (out_lane),
  .out_last_of_item (out_last_of_item)
);
